FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and field layout for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int OccW  = $clog2(DEPTH + 1);

  localparam int TagW  = 32;
  localparam int LvlW  = 3;
  localparam int MinW  = 10;
  localparam int PendW = 5;
  localparam int TotW  = 32;

  // input tdata layout
  localparam int InTagLo = 0;
  localparam int InLvlLo = InTagLo + TagW;
  localparam int InMinLo = InLvlLo + LvlW;
  localparam int InUsed  = InMinLo + MinW;
  localparam int InDataW = ((InUsed + 7) / 8) * 8;

  // output tdata layout
  localparam int OutTagLo  = 0;
  localparam int OutLvlLo  = OutTagLo + TagW;
  localparam int OutMinLo  = OutLvlLo + LvlW;
  localparam int OutPendLo = OutMinLo + MinW;
  localparam int OutCntLo  = OutPendLo + PendW;
  localparam int OutSumLo  = OutCntLo + TotW;
  localparam int OutUsed   = OutSumLo + TotW;
  localparam int OutDataW  = ((OutUsed + 7) / 8) * 8;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_SERVE  = 1'b1
  } spq_kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_e;

  typedef enum logic {
    OUT_IDLE = 1'b0,
    OUT_HOLD = 1'b1
  } spq_state_e;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [LvlW-1:0] level;
    logic [MinW-1:0] minutes;
  } spq_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // run the accepted item and load the result register
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage

FILE: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: tracks the result register and issues execute.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t  cmd_o
);
  import spq_pkg::*;

  spq_state_e state_q, state_d;
  logic       unused_stat;

  // occupancy flags are resolved inside the datapath per item
  assign unused_stat = stat_i.empty & stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OUT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    m_valid_o = 1'b0;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      OUT_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = OUT_HOLD;
        end
      end
      OUT_HOLD: begin
        m_valid_o = 1'b1;
        // result taken this cycle frees the register for a new item
        s_ready_o = m_ready_i;
        if (m_ready_i) begin
          if (s_valid_i) begin
            cmd_o.exec = 1'b1;
          end else begin
            state_d = OUT_IDLE;
          end
        end
      end
      default: state_d = OUT_IDLE;
    endcase
  end

endmodule

FILE: rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted shift-register slots, totals and the registered result.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spq_pkg::spq_cmd_t             cmd_i,
  output spq_pkg::spq_stat_t            stat_o,
  input  logic                          in_kind_i,
  input  logic [spq_pkg::InDataW-1:0]   in_data_i,
  output logic [1:0]                    out_status_o,
  output logic [spq_pkg::OutDataW-1:0]  out_data_o
);
  import spq_pkg::*;

  spq_entry_t             slot_q [DEPTH];
  spq_entry_t             slot_d [DEPTH];
  spq_entry_t             slot_dn [DEPTH];
  spq_entry_t             slot_fw [DEPTH];
  spq_entry_t             new_entry;
  spq_entry_t             front;
  logic [DEPTH-1:0]       le;
  logic [DEPTH-1:0]       le_prev;
  logic [OccW-1:0]        occ_q, occ_d;
  logic [TotW-1:0]        cnt_q, cnt_d;
  logic [TotW-1:0]        sum_q, sum_d;
  logic [TotW:0]          cnt_inc;
  logic [TotW:0]          sum_inc;
  logic                   is_full, is_empty;
  logic                   do_insert, do_serve;
  spq_status_e            status_d;
  logic [OccW+PendW-1:0]  pend_ext;
  logic [1:0]             status_q;
  logic [OutDataW-1:0]    data_q, data_d;

  assign new_entry.tag     = in_data_i[InTagLo +: TagW];
  assign new_entry.level   = in_data_i[InLvlLo +: LvlW];
  assign new_entry.minutes = in_data_i[InMinLo +: MinW];
  assign front             = slot_q[0];

  assign is_full   = (occ_q == OccW'(DEPTH));
  assign is_empty  = (occ_q == '0);
  assign stat_o.full  = is_full;
  assign stat_o.empty = is_empty;

  assign do_insert = (in_kind_i == KIND_INSERT) && !is_full;
  assign do_serve  = (in_kind_i == KIND_SERVE) && !is_empty;

  // slots that stay ahead of the new entry form a prefix since the list is sorted
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (OccW'(i) < occ_q) && (slot_q[i].level <= new_entry.level);
    end
  end
  assign le_prev = {le[DEPTH-2:0], 1'b0};

  always_comb begin
    slot_dn[0]       = new_entry;
    slot_fw[DEPTH-1] = slot_q[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      slot_dn[i]   = slot_q[i-1];
      slot_fw[i-1] = slot_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_d[i] = slot_q[i];
      if (do_insert && !le[i]) begin
        slot_d[i] = le_prev[i] ? new_entry : slot_dn[i];
      end else if (do_serve) begin
        slot_d[i] = slot_fw[i];
      end
    end
  end

  assign cnt_inc = {1'b0, cnt_q} + {{TotW{1'b0}}, 1'b1};
  assign sum_inc = {1'b0, sum_q} + {{(TotW + 1 - MinW){1'b0}}, front.minutes};

  always_comb begin
    occ_d    = occ_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    status_d = ST_OK;
    if (in_kind_i == KIND_INSERT) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        occ_d = occ_q + OccW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        occ_d = occ_q - OccW'(1);
        cnt_d = cnt_inc[TotW] ? {TotW{1'b1}} : cnt_inc[TotW-1:0];
        sum_d = sum_inc[TotW] ? {TotW{1'b1}} : sum_inc[TotW-1:0];
      end
    end
  end

  assign pend_ext = {{PendW{1'b0}}, occ_d};

  always_comb begin
    data_d = '0;
    if (do_serve) begin
      data_d[OutTagLo +: TagW] = front.tag;
      data_d[OutLvlLo +: LvlW] = front.level;
      data_d[OutMinLo +: MinW] = front.minutes;
    end
    data_d[OutPendLo +: PendW] = pend_ext[PendW-1:0];
    data_d[OutCntLo +: TotW]   = cnt_d;
    data_d[OutSumLo +: TotW]   = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.exec) begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_q[i] <= slot_d[i];
      end
      status_q <= status_d;
      data_q   <= data_d;
    end
  end

  assign out_status_o = status_q;
  assign out_data_o   = data_q;

endmodule

FILE: rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded stable priority queue with insert and serve items.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one item per handshake: tuser is the kind
//   (insert or serve), tdata holds tag, level and minutes of an insert.
//   Master channel returns exactly one result per item: tuser is the
//   status, tdata the served entry, pending count and running totals.
//   The result is valid in the cycle after the item is taken.
//   Throughput: one item per cycle while m_axis_tready is high; slots are a
//   shift register with a compare per slot, so all slots update at once.
//   The result register is the only buffer: while a result waits,
//   s_axis_tready follows m_axis_tready, so a stalled receiver holds off
//   new items and the pending result stays stable.
//   Reset empties the queue and clears both totals; slot contents are
//   not cleared since only occupied slots are ever read.
//   Queue depth is 16 entries; an insert into a full queue is rejected.
// ----------------------------------------------------------------------------
module stable_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] entry_tag, [34:32] level, [44:35] minutes, [47:45] zero
  input  logic [spq_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] served_tag, [34:32] served_level, [44:35] served_minutes,
  // [49:45] pending, [81:50] served_total, [113:82] minutes_total, [119:114] zero
  output logic [spq_pkg::OutDataW-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]                    m_axis_tuser
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  spq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_kind_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

endmodule

FILE: rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the stable priority queue.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [spq_pkg::InDataW-1:0]   s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [spq_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);
  import spq_pkg::*;

  logic [OutPendLo-1:0] served_bits;
  logic [PendW-1:0]     pend;

  assign served_bits = m_axis_tdata[OutPendLo-1:0];
  assign pend        = m_axis_tdata[OutPendLo +: PendW];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no result waiting means the input side is open
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result register");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (served_bits == '0) && (pend == '0))
    else $error("empty serve returned data");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
      (served_bits == '0) && (pend == PendW'(DEPTH)))
    else $error("rejected insert with wrong pending count");

  // an accepted serve item yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_SERVE) && (s_axis_tdata == s_axis_tdata)
      |=> m_axis_tvalid)
    else $error("accepted item produced no result");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
